### design/tlrh_pkg.sv
// Package for the two-level rectangle hit test.
// Holds payload structs, request codes, stored entry types and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package tlrh_pkg;

	localparam int MAX_PANELS_DEF        = 8;
	localparam int DEVICES_PER_PANEL_DEF = 32;

	localparam logic [1:0] REQ_WR_PANEL   = 2'd0;
	localparam logic [1:0] REQ_WR_DEVICE  = 2'd1;
	localparam logic [1:0] REQ_LOC_DEVICE = 2'd2;
	localparam logic [1:0] REQ_LOC_PANEL  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         panel_index;
		logic [4:0]         device_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0]        rect_w;
		logic [14:0]        rect_h;
		logic               panel_active;
		logic               panel_withdrawn;
		logic [5:0]         device_count;
	} in_t;

	typedef struct packed {
		logic       panel_found;
		logic [2:0] panel_number;
		logic       device_found;
		logic [4:0] device_number;
	} out_t;

	// Rectangle held as left/top edge and exclusive right/bottom edge.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [16:0] xe;
		logic signed [15:0] y;
		logic signed [16:0] ye;
	} rect_t;

	typedef struct packed {
		rect_t      rect;
		logic [5:0] cnt;
	} panel_ent_t;

	typedef struct packed {
		logic accept;
		logic wr_panel;
		logic wr_dev;
		logic p_step;
		logic p_take;
		logic d_step;
		logic d_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic p_hit;
		logic p_last;
		logic d_hit;
		logic d_last;
	} status_t;

endpackage

### design/tlrh_ctrl.sv
// Controller of the two-level rectangle hit test: request decode, panel
// and device scan sequencing, output register handshake.
// Depends on tlrh_pkg.
`timescale 1ns / 1ps

module tlrh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	output logic               out_valid,
	input  logic               out_stall,
	output tlrh_pkg::cmd_t     cmd,
	input  tlrh_pkg::status_t  st
);
	import tlrh_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PSCAN = 2'd1;
	localparam logic [1:0] S_DSCAN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       dev_mode_q;
	logic       out_valid_q;
	logic       slot_free;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		in_stall  = (state_q != S_IDLE);
		slot_free = !out_valid_q || !out_stall;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (req_type)
						REQ_WR_PANEL: begin
							cmd.wr_panel = 1'b1;
							state_d      = S_DONE;
						end
						REQ_WR_DEVICE: begin
							cmd.wr_dev = 1'b1;
							state_d    = S_DONE;
						end
						REQ_LOC_DEVICE, REQ_LOC_PANEL: begin
							state_d = S_PSCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_PSCAN: begin
				priority if (st.p_hit) begin
					cmd.p_take = 1'b1;
					state_d    = dev_mode_q ? S_DSCAN : S_DONE;
				end else if (st.p_last) begin
					state_d = S_DONE;
				end else begin
					cmd.p_step = 1'b1;
				end
			end
			S_DSCAN: begin
				priority if (st.d_hit) begin
					cmd.d_take = 1'b1;
					state_d    = S_DONE;
				end else if (st.d_last) begin
					state_d = S_DONE;
				end else begin
					cmd.d_step = 1'b1;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dev_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				dev_mode_q <= (req_type == REQ_LOC_DEVICE);
			end
			// hold the result until the receiver takes it
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/tlrh_dp.sv
// Datapath of the two-level rectangle hit test: panel and device tables,
// scan counters, containment compares, result and output registers.
// Depends on tlrh_pkg.
`timescale 1ns / 1ps

module tlrh_dp #(
	parameter int MAX_PANELS        = tlrh_pkg::MAX_PANELS_DEF,
	parameter int DEVICES_PER_PANEL = tlrh_pkg::DEVICES_PER_PANEL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  tlrh_pkg::in_t      in_data,
	input  tlrh_pkg::cmd_t     cmd,
	output tlrh_pkg::status_t  st,
	output tlrh_pkg::out_t     out_data
);
	import tlrh_pkg::*;

	localparam int PI_W  = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
	localparam int PC_W  = $clog2(MAX_PANELS + 1);
	localparam int PCMPW = (PC_W > 4) ? PC_W : 4;
	localparam int DI_W  = (DEVICES_PER_PANEL > 1) ? $clog2(DEVICES_PER_PANEL) : 1;
	localparam int DC_W  = $clog2(DEVICES_PER_PANEL + 1);
	localparam int DCMPW = (DC_W > 6) ? DC_W : 6;
	localparam int DEPTH = MAX_PANELS * DEVICES_PER_PANEL;
	localparam int DA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	panel_ent_t pmem [MAX_PANELS];
	rect_t      dmem [DEPTH];
	logic       elig_q [MAX_PANELS];

	logic [3:0]         pcount_q;
	logic [PCMPW-1:0]   pcount_ext;
	logic [PC_W-1:0]    plim;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	rect_t              wr_rect;
	logic               pi_ok;
	logic               di_ok;
	logic [DA_W-1:0]    dmem_wa;
	logic [DA_W-1:0]    dmem_ra;

	logic [PC_W-1:0]    p_addr_q;
	logic               p_vld_s1;
	logic               p_inr_s1;
	logic [PC_W-1:0]    p_idx_s1;
	panel_ent_t         p_rd_s1;
	logic [PI_W-1:0]    p_num_q;

	logic [DC_W-1:0]    d_addr_q;
	logic [DC_W-1:0]    dlim_q;
	logic               d_vld_s1;
	logic               d_inr_s1;
	logic [DC_W-1:0]    d_idx_s1;
	rect_t              d_rd_s1;
	logic signed [16:0] rx_q;
	logic signed [16:0] ry_q;

	logic [DCMPW-1:0]   cnt_ext;
	logic [DC_W-1:0]    dlim_d;
	logic               p_holds;
	logic               d_holds;
	out_t               res_q;
	out_t               out_q;

	always_comb begin
		pcount_ext = PCMPW'(pcount_q);
		plim = (pcount_ext > PCMPW'(MAX_PANELS)) ? PC_W'(MAX_PANELS) : PC_W'(pcount_ext);

		wr_rect.x  = in_data.rect_x;
		wr_rect.y  = in_data.rect_y;
		wr_rect.xe = {in_data.rect_x[15], in_data.rect_x} + $signed({2'b00, in_data.rect_w});
		wr_rect.ye = {in_data.rect_y[15], in_data.rect_y} + $signed({2'b00, in_data.rect_h});

		pi_ok   = (32'(in_data.panel_index) < MAX_PANELS);
		di_ok   = (32'(in_data.device_index) < DEVICES_PER_PANEL);
		dmem_wa = DA_W'(32'(in_data.panel_index) * DEVICES_PER_PANEL
		                + 32'(in_data.device_index));
		dmem_ra = DA_W'(32'(p_num_q) * DEVICES_PER_PANEL + 32'(d_addr_q));

		p_holds = ($signed({p_rd_s1.rect.x[15], p_rd_s1.rect.x}) <= $signed({px_q[15], px_q}))
		       && ($signed(p_rd_s1.rect.xe) > $signed({px_q[15], px_q}))
		       && ($signed({p_rd_s1.rect.y[15], p_rd_s1.rect.y}) <= $signed({py_q[15], py_q}))
		       && ($signed(p_rd_s1.rect.ye) > $signed({py_q[15], py_q}));
		d_holds = ($signed({d_rd_s1.x[15], d_rd_s1.x}) <= rx_q)
		       && ($signed(d_rd_s1.xe) > rx_q)
		       && ($signed({d_rd_s1.y[15], d_rd_s1.y}) <= ry_q)
		       && ($signed(d_rd_s1.ye) > ry_q);

		st.p_hit  = p_vld_s1 && p_inr_s1 && p_holds;
		st.p_last = p_vld_s1 && ((PC_W + 1)'(p_idx_s1) + 1'b1 >= (PC_W + 1)'(plim));
		st.d_hit  = d_vld_s1 && d_inr_s1 && d_holds;
		st.d_last = d_vld_s1 && ((DC_W + 1)'(d_idx_s1) + 1'b1 >= (DC_W + 1)'(dlim_q));

		cnt_ext = DCMPW'(p_rd_s1.cnt);
		dlim_d  = (cnt_ext > DCMPW'(DEVICES_PER_PANEL)) ? DC_W'(DEVICES_PER_PANEL)
		                                                : DC_W'(cnt_ext);
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.wr_panel && pi_ok) begin
			pmem[in_data.panel_index[PI_W-1:0]] <= '{rect: wr_rect, cnt: in_data.device_count};
		end
		if (cmd.wr_dev && pi_ok && di_ok) begin
			dmem[dmem_wa] <= wr_rect;
		end
		if (cmd.p_step) begin
			p_rd_s1 <= pmem[p_addr_q[PI_W-1:0]];
		end
		if (cmd.d_step) begin
			d_rd_s1 <= dmem[dmem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PANELS; i++) begin
				elig_q[i] <= 1'b0;
			end
			pcount_q <= '0;
			p_addr_q <= '0;
			p_vld_s1 <= 1'b0;
			d_addr_q <= '0;
			d_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				pcount_q <= cfg_wdata;
			end
			if (cmd.wr_panel && pi_ok) begin
				elig_q[in_data.panel_index[PI_W-1:0]] <=
					in_data.panel_active && !in_data.panel_withdrawn;
			end
			p_vld_s1 <= cmd.p_step;
			d_vld_s1 <= cmd.d_step;
			if (cmd.accept) begin
				p_addr_q <= '0;
			end else if (cmd.p_step) begin
				p_addr_q <= p_addr_q + 1'b1;
			end
			if (cmd.p_take) begin
				d_addr_q <= '0;
			end else if (cmd.d_step) begin
				d_addr_q <= d_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q  <= in_data.point_x;
			py_q  <= in_data.point_y;
			res_q <= '0;
		end
		if (cmd.p_step) begin
			p_idx_s1 <= p_addr_q;
			p_inr_s1 <= (p_addr_q < plim) && elig_q[p_addr_q[PI_W-1:0]];
		end
		if (cmd.d_step) begin
			d_idx_s1 <= d_addr_q;
			d_inr_s1 <= (d_addr_q < dlim_q);
		end
		// latch the matched panel and make the point relative to its corner
		if (cmd.p_take) begin
			p_num_q            <= p_idx_s1[PI_W-1:0];
			dlim_q             <= dlim_d;
			rx_q               <= {px_q[15], px_q} - {p_rd_s1.rect.x[15], p_rd_s1.rect.x};
			ry_q               <= {py_q[15], py_q} - {p_rd_s1.rect.y[15], p_rd_s1.rect.y};
			res_q.panel_found  <= 1'b1;
			res_q.panel_number <= 3'(p_idx_s1);
		end
		if (cmd.d_take) begin
			res_q.device_found  <= 1'b1;
			res_q.device_number <= 5'(d_idx_s1);
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign out_data = out_q;

endmodule

### design/two_level_rectangle_hit_test.sv
// Two-level rectangle hit test, top level.
// Joins the controller (tlrh_ctrl) and the datapath (tlrh_dp); uses tlrh_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request per
//   transfer: write a panel entry, write a device entry, locate a point down
//   to a device, or locate a point to a panel only. Every request yields
//   exactly one result on out_valid / out_stall / out_data; writes return
//   an all-zero result.
//   cfg_we / cfg_wdata set the number of panel entries searched; write it
//   only while no request is in flight.
// Sequencing:
//   A write result is loaded into the output register once it is free. A
//   locate scans the panel entries in order up to the first hit or the last
//   searched entry; a device locate then scans the device entries of the
//   matched panel the same way. The tables are read one entry a cycle
//   through a registered memory port. One request is processed at a time;
//   the next is taken the cycle after the result enters the output
//   register.
// Reset clears the panel flags (no panel is eligible) and the searched
// panel count. A stalled result holds in the output register; the block may
// take one more request, then holds that result and stalls its input until
// the output register frees.
`timescale 1ns / 1ps

module two_level_rectangle_hit_test #(
	parameter int MAX_PANELS        = tlrh_pkg::MAX_PANELS_DEF,
	parameter int DEVICES_PER_PANEL = tlrh_pkg::DEVICES_PER_PANEL_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  tlrh_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output tlrh_pkg::out_t out_data
);
	import tlrh_pkg::*;

	cmd_t    cmd;
	status_t st;

	tlrh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (in_data.req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

	tlrh_dp #(
		.MAX_PANELS        (MAX_PANELS),
		.DEVICES_PER_PANEL (DEVICES_PER_PANEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a request was in flight");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten before transfer");

	a_device_needs_panel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.device_found) |-> out_data.panel_found)
		else $error("device reported without a panel");

	a_no_panel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.panel_found) |->
		(out_data.panel_number == 3'd0 && !out_data.device_found))
		else $error("nonzero fields in a no-panel result");
`endif

endmodule
